FILE: rtl/core/u8dec_pkg.sv
// Shared types and constants for the UTF-8 validating decoder.
// No dependencies; compiled first.
package u8dec_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int USED_W = 3;
  localparam int LEN_W  = 3;
  localparam int HELD_W = 2;
  localparam int CNT_W  = 2;

  // Sequence length codes (LEN_NONE: no sequence open)
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

  localparam logic [USED_W-1:0] USED_ONE = 3'd1;

  // Code point limits
  localparam logic [CP_W-1:0] CP_MIN2    = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN3    = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN4    = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI = 21'h00DFFF;

  // Results caused by one input byte: some 1-byte invalids, then an optional final result
  typedef struct packed {
    logic [CNT_W-1:0]  inv_cnt;
    logic              fin_pres;
    logic [CP_W-1:0]   fin_cp;
    logic              fin_valid;
    logic [USED_W-1:0] fin_used;
  } u8dec_burst_t;

endpackage

FILE: rtl/core/u8dec_if.sv
// Valid/ready channel interfaces for the decoder's byte input and result output.
// Depends on u8dec_pkg.
interface u8dec_in_if import u8dec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8dec_out_if import u8dec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CP_W-1:0]   code_point;
  logic              valid_res;
  logic [USED_W-1:0] bytes_used;
  logic              run_last;

  modport source (output valid, output code_point, output valid_res, output bytes_used,
                  output run_last, input ready);
  modport sink (input valid, input code_point, input valid_res, input bytes_used,
                input run_last, output ready);
endinterface

FILE: rtl/core/utf8_validating_decoder_core.sv
// Top level of the UTF-8 validating decoder: config register, decode, result register.
// Depends on u8dec_pkg, u8dec_if, u8dec_decode, u8dec_burst.
//
//   channel   dir   payload                                        handshake
//   in_ch     in    text_byte[7:0], end_of_text                    valid/ready
//   out_ch    out   code_point[20:0], valid_res, bytes_used[2:0],  valid/ready
//                   run_last
//   cfg       in    cfg_wr_data (drop_invalid)                     cfg_wr_en
//
// One byte per cycle while no results are pending; a byte's first result appears
// the cycle after it is taken. The burst result register holds the input until a
// byte's last result is taken (up to 4 results); bytes that cause none do not hold it.
// rst is synchronous, active high; it closes any open sequence and clears drop_invalid.
// A stall on out_ch holds the current result and stops input.
module utf8_validating_decoder_core import u8dec_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  u8dec_in_if.sink  in_ch,
  u8dec_out_if.source out_ch,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);

  logic         drop_invalid;
  logic         accept;
  logic         in_ready;
  u8dec_burst_t burst;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_invalid <= 1'b0;
    end else if (cfg_wr_en) begin
      drop_invalid <= cfg_wr_data;
    end
  end

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  u8dec_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .text_byte    (in_ch.text_byte),
    .end_of_text  (in_ch.end_of_text),
    .drop_invalid (drop_invalid),
    .burst        (burst)
  );

  u8dec_burst u_burst (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .burst      (burst),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .code_point (out_ch.code_point),
    .valid_res  (out_ch.valid_res),
    .bytes_used (out_ch.bytes_used),
    .run_last   (out_ch.run_last),
    .in_ready   (in_ready)
  );

endmodule

FILE: rtl/core/u8dec_decode.sv
// Sequence state and per-byte decode: turns one accepted byte into a result burst.
// Depends on u8dec_pkg.
module u8dec_decode import u8dec_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic              end_of_text,
  input  logic              drop_invalid,
  output u8dec_burst_t      burst
);

  logic [LEN_W-1:0]  seq_len, seq_len_next;
  logic [HELD_W-1:0] held, held_next;
  logic [CP_W-1:0]   pv, pv_next;

  logic [CP_W-1:0]   pv_shift;
  logic [HELD_W-1:0] held_inc;
  logic [CP_W-1:0]   cp_min;
  logic              cp_ok;
  logic              lead_en;
  logic [LEN_W-1:0]  lead_len;
  logic [CP_W-1:0]   lead_val;
  logic [CNT_W-1:0]  flush_cnt;
  logic              fin_pres;
  logic [CP_W-1:0]   fin_cp;
  logic              fin_valid;
  logic [USED_W-1:0] fin_used;

  assign pv_shift = {pv[CP_W-7:0], text_byte[5:0]};
  assign held_inc = held + 2'd1;

  // Range check of a completed sequence
  always_comb begin
    case (seq_len)
      LEN_2:   cp_min = CP_MIN2;
      LEN_3:   cp_min = CP_MIN3;
      default: cp_min = CP_MIN4;
    endcase
    cp_ok = (pv_shift >= cp_min) && (pv_shift <= CP_MAX) &&
            !((pv_shift >= CP_SURR_LO) && (pv_shift <= CP_SURR_HI));
  end

  // Lead byte classification
  always_comb begin
    lead_len = LEN_NONE;
    lead_val = '0;
    if (text_byte[7:5] == 3'b110) begin
      lead_len = LEN_2;
      lead_val = {16'd0, text_byte[4:0]};
    end else if (text_byte[7:4] == 4'b1110) begin
      lead_len = LEN_3;
      lead_val = {17'd0, text_byte[3:0]};
    end else if (text_byte[7:3] == 5'b11110) begin
      lead_len = LEN_4;
      lead_val = {18'd0, text_byte[2:0]};
    end
  end

  // Next state and result burst
  always_comb begin
    seq_len_next = seq_len;
    held_next    = held;
    pv_next      = pv;
    flush_cnt    = '0;
    lead_en      = 1'b0;
    fin_pres     = 1'b0;
    fin_cp       = '0;
    fin_valid    = 1'b0;
    fin_used     = USED_ONE;

    if (seq_len == LEN_NONE) begin
      lead_en = 1'b1;
    end else if (text_byte[7:6] == 2'b10) begin
      if (({1'b0, held_inc} >= seq_len) || (held_inc == '0)) begin
        // sequence complete
        fin_pres     = 1'b1;
        fin_cp       = pv_shift;
        fin_valid    = cp_ok;
        fin_used     = seq_len;
        seq_len_next = LEN_NONE;
        held_next    = '0;
        pv_next      = '0;
      end else if (end_of_text) begin
        // cut off: every held byte plus this one goes out invalid
        flush_cnt    = held_inc;
        seq_len_next = LEN_NONE;
        held_next    = '0;
        pv_next      = '0;
      end else begin
        held_next = held_inc;
        pv_next   = pv_shift;
      end
    end else begin
      // bad continuation: flush held bytes, restart on this byte
      flush_cnt    = held;
      seq_len_next = LEN_NONE;
      held_next    = '0;
      pv_next      = '0;
      lead_en      = 1'b1;
    end

    if (lead_en) begin
      if (!text_byte[7]) begin
        fin_pres  = 1'b1;
        fin_valid = 1'b1;
        fin_cp    = {13'd0, text_byte};
      end else if (lead_len == LEN_NONE || end_of_text) begin
        fin_pres = 1'b1;
      end else begin
        seq_len_next = lead_len;
        held_next    = 2'd1;
        pv_next      = lead_val;
      end
    end

    if (!fin_valid) begin
      fin_cp = '0;
    end
    if (drop_invalid) begin
      flush_cnt = '0;
      if (!fin_valid) begin
        fin_pres = 1'b0;
      end
    end
  end

  assign burst = '{inv_cnt: flush_cnt, fin_pres: fin_pres, fin_cp: fin_cp,
                   fin_valid: fin_valid, fin_used: fin_used};

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= LEN_NONE;
      held    <= '0;
      pv      <= '0;
    end else if (accept) begin
      seq_len <= seq_len_next;
      held    <= held_next;
      pv      <= pv_next;
    end
  end

`ifndef SYNTHESIS
  a_eot_closes: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_text |=> seq_len == LEN_NONE)
    else $error("sequence left open after end of text");
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    seq_len != LEN_NONE |-> held != '0 && {1'b0, held} < seq_len)
    else $error("held byte count out of range for open sequence");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    seq_len == LEN_NONE |-> held == '0 && pv == '0)
    else $error("state not cleared with no sequence open");
`endif

endmodule

FILE: rtl/core/u8dec_burst.sv
// Result register: holds a byte's result burst, issuing one result per cycle of out_ready.
// Depends on u8dec_pkg.
module u8dec_burst import u8dec_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  u8dec_burst_t      burst,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CP_W-1:0]   code_point,
  output logic              valid_res,
  output logic [USED_W-1:0] bytes_used,
  output logic              run_last,
  output logic              in_ready
);

  logic [CNT_W-1:0]  inv_cnt;
  logic              fin_pres;
  logic [CP_W-1:0]   fin_cp;
  logic              fin_valid;
  logic [USED_W-1:0] fin_used;
  logic              busy;
  logic              cur_inv;
  logic              step;

  assign busy    = (inv_cnt != '0) || fin_pres;
  assign cur_inv = (inv_cnt != '0);
  assign step    = busy && out_ready;

  // Current result: pending 1-byte invalids first, then the final one
  assign out_valid  = busy;
  assign code_point = cur_inv ? '0 : fin_cp;
  assign valid_res  = cur_inv ? 1'b0 : fin_valid;
  assign bytes_used = cur_inv ? USED_ONE : fin_used;
  assign run_last   = cur_inv ? ((inv_cnt == 2'd1) && !fin_pres) : 1'b1;

  // Take a new item when empty or as the last result leaves
  assign in_ready = !busy || (out_ready && run_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_cnt  <= '0;
      fin_pres <= 1'b0;
    end else if (load) begin
      inv_cnt  <= burst.inv_cnt;
      fin_pres <= burst.fin_pres;
    end else if (step) begin
      if (cur_inv) begin
        inv_cnt <= inv_cnt - 2'd1;
      end else begin
        fin_pres <= 1'b0;
      end
    end
  end

  // Payload of the final result
  always_ff @(posedge clk) begin
    if (load) begin
      fin_cp    <= burst.fin_cp;
      fin_valid <= burst.fin_valid;
      fin_used  <= burst.fin_used;
    end
  end

`ifndef SYNTHESIS
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    busy && !out_ready |-> !in_ready)
    else $error("input taken while a result is stalled");
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    step && !run_last |=> busy)
    else $error("burst ended before its last result");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> code_point == '0)
    else $error("invalid result carries a nonzero code point");
`endif

endmodule
